### design/rnlb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rnlb_pkg;

  // Field widths
  localparam int LOAD_W      = 10;
  localparam int IVL_W       = 10;
  localparam int TICK_W      = 20;
  localparam int IDX_FIELD_W = 4;

  // Ring size default and register reset
  localparam int NUM_PROCS_DEF = 5;
  localparam logic [TICK_W-1:0] MAX_TICKS_RST = TICK_W'(999999);

  // Floor divide by three of a three-load sum: multiply by reciprocal, then shift
  localparam int DIV3_SHIFT = LOAD_W + 4;
  localparam int DIV3_MULT  = (2 ** DIV3_SHIFT + 2) / 3;

  typedef enum logic [0:0] {
    OP_SET  = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef struct packed {
    op_t                    operation;
    logic [IDX_FIELD_W-1:0] proc_index;
    logic [LOAD_W-1:0]      load_value;
    logic [IVL_W-1:0]       interval_value;
  } req_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_count;
    logic              all_steady;
    logic              balanced;
    logic              timed_out;
    logic              stopped;
  } rsp_t;

  // Commands to the per-processor phase counters
  typedef struct packed {
    logic                   set_en;
    logic                   tick_en;
    logic [IDX_FIELD_W-1:0] proc_index;
    logic [IVL_W-1:0]       interval;
  } phase_cmd_t;

  typedef enum logic [1:0] {
    ALU_ADD3,
    ALU_DIV3,
    ALU_DIVN,
    ALU_DEV
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEL,
    ST_RD_OWN,
    ST_RD_LF,
    ST_RD_RT,
    ST_SUM3,
    ST_DIV3,
    ST_WR_LF,
    ST_WR_RT,
    ST_WR_OWN,
    ST_STOP,
    ST_CHECK,
    ST_SUM,
    ST_MEAN,
    ST_DEV
  } state_t;

endpackage

`default_nettype wire

### design/ring_neighbor_load_balancer.sv
`timescale 1ns / 1ps
`default_nettype none
// A set item or an ignored tick goes from the accepting cycle through ST_CHECK to the result strobe;
// a running tick first visits each due processor in turn. Whenever all processors are steady, a sum
// and a deviation sweep follow: one load memory port and one shared unit serve every step in turn.
// Throughput: one request at a time; busy stays high until the result strobe; no stalls.
// Reset (rst, synchronous): loads read as zero, flags and tick count clear, max_ticks 999999.

module ring_neighbor_load_balancer import rnlb_pkg::*; #(
  parameter int NUM_PROCS = NUM_PROCS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  req_t              request,
  output logic              busy,
  output logic              done,
  output rsp_t              result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TICK_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(NUM_PROCS);
  localparam int PCNT_W = $clog2(NUM_PROCS + 1);
  localparam int ACC_W  = LOAD_W + $clog2(NUM_PROCS);
  localparam logic [PCNT_W-1:0] LAST_CNT = PCNT_W'(NUM_PROCS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(NUM_PROCS - 1);

  state_t               state, state_next;
  logic [PCNT_W-1:0]    pidx;
  logic [IDX_W-1:0]     paddr, lf_addr, rt_addr, sweep_addr, req_addr;
  logic [LOAD_W-1:0]    own_ld, lf_ld, rt_ld, avg, mean;
  logic [ACC_W-1:0]     acc;
  logic                 bal;
  logic [NUM_PROCS-1:0] steady;
  logic [TICK_W-1:0]    tick, max_ticks;
  logic                 stopped;
  logic                 accept, req_ok, all_steady;

  logic                 mem_we;
  logic [IDX_W-1:0]     mem_waddr, mem_raddr;
  logic [LOAD_W-1:0]    mem_wdata, mem_rdata;

  alu_op_t              alu_op;
  logic [ACC_W-1:0]     alu_a, alu_b, alu_c, alu_y;

  phase_cmd_t           phase_cmd;
  logic [NUM_PROCS-1:0] visit_mask;

  logic                 give, lf_short, rt_short, gave;
  logic [LOAD_W-1:0]    gl, gr, lf_new, rt_new, own_new;

  rnlb_load_mem #(.NUM_PROCS(NUM_PROCS)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rnlb_alu #(.NUM_PROCS(NUM_PROCS)) u_alu (
    .op (alu_op),
    .a  (alu_a),
    .b  (alu_b),
    .c  (alu_c),
    .y  (alu_y)
  );

  rnlb_phase #(.NUM_PROCS(NUM_PROCS)) u_phase (
    .clk        (clk),
    .rst        (rst),
    .cmd        (phase_cmd),
    .visit_mask (visit_mask)
  );

  // Handshake and ring addressing
  assign busy       = (state != ST_IDLE);
  assign cfg_ready  = (state == ST_IDLE);
  assign accept     = start && !busy;
  assign req_ok     = {1'b0, request.proc_index} < (IDX_FIELD_W + 1)'(NUM_PROCS);
  assign req_addr   = request.proc_index[IDX_W-1:0];
  assign all_steady = &steady;
  assign paddr      = pidx[IDX_W-1:0];
  assign lf_addr    = (paddr == '0) ? LAST_IDX : paddr - IDX_W'(1);
  assign rt_addr    = (paddr == LAST_IDX) ? '0 : paddr + IDX_W'(1);
  assign sweep_addr = (pidx < LAST_CNT) ? paddr : '0;

  always_comb begin
    phase_cmd.set_en     = accept && (request.operation == OP_SET) && req_ok;
    phase_cmd.tick_en    = accept && (request.operation == OP_TICK) && !stopped;
    phase_cmd.proc_index = request.proc_index;
    phase_cmd.interval   = request.interval_value;
  end

  // Top up poorer neighbors to the average, paid from the own load
  always_comb begin
    give     = own_ld > avg;
    lf_short = lf_ld < avg;
    rt_short = rt_ld < avg;
    gl       = (give && lf_short) ? avg - lf_ld : '0;
    gr       = (give && rt_short) ? avg - rt_ld : '0;
    lf_new   = lf_ld + gl;
    rt_new   = rt_ld + gr;
    own_new  = own_ld - gl - gr;
    gave     = give && (lf_short || rt_short);
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, memory port and shared unit selection
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = paddr;
    mem_wdata  = own_new;
    mem_raddr  = sweep_addr;
    alu_op     = ALU_ADD3;
    alu_a      = acc;
    alu_b      = ACC_W'(mem_rdata);
    alu_c      = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          if (request.operation == OP_SET && req_ok) begin
            mem_we    = 1'b1;
            mem_waddr = req_addr;
            mem_wdata = request.load_value;
          end
          if (request.operation == OP_TICK && !stopped) begin
            state_next = ST_SEL;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_SEL: begin
        priority if (pidx == LAST_CNT) begin
          state_next = ST_STOP;
        end else if (visit_mask[paddr]) begin
          state_next = ST_RD_OWN;
        end
      end
      ST_RD_OWN: begin
        mem_raddr  = paddr;
        state_next = ST_RD_LF;
      end
      ST_RD_LF: begin
        mem_raddr  = lf_addr;
        state_next = ST_RD_RT;
      end
      ST_RD_RT: begin
        mem_raddr  = rt_addr;
        state_next = ST_SUM3;
      end
      ST_SUM3: begin
        alu_a      = ACC_W'(own_ld);
        alu_b      = ACC_W'(lf_ld);
        alu_c      = ACC_W'(mem_rdata);
        state_next = ST_DIV3;
      end
      ST_DIV3: begin
        alu_op     = ALU_DIV3;
        state_next = ST_WR_LF;
      end
      ST_WR_LF: begin
        mem_we     = 1'b1;
        mem_waddr  = lf_addr;
        mem_wdata  = lf_new;
        state_next = ST_WR_RT;
      end
      ST_WR_RT: begin
        mem_we     = 1'b1;
        mem_waddr  = rt_addr;
        mem_wdata  = rt_new;
        state_next = ST_WR_OWN;
      end
      ST_WR_OWN: begin
        mem_we     = 1'b1;
        state_next = ST_SEL;
      end
      ST_STOP: begin
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        state_next = all_steady ? ST_SUM : ST_IDLE;
      end
      ST_SUM: begin
        if (pidx == LAST_CNT) begin
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        alu_op     = ALU_DIVN;
        state_next = ST_DEV;
      end
      ST_DEV: begin
        alu_op = ALU_DEV;
        alu_a  = ACC_W'(mem_rdata);
        alu_b  = ACC_W'(mean);
        if (pidx == LAST_CNT) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers: steady marks, tick count, stop flag, timeout limit, sequencer index, strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      steady    <= '0;
      tick      <= '0;
      stopped   <= 1'b0;
      max_ticks <= MAX_TICKS_RST;
      pidx      <= '0;
      done      <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        max_ticks <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          pidx <= '0;
          if (accept) begin
            if (request.operation == OP_SET) begin
              if (req_ok) begin
                steady[req_addr] <= 1'b0;
                tick             <= '0;
                stopped          <= 1'b0;
              end
            end else if (!stopped) begin
              tick <= tick + TICK_W'(1);
            end
          end
        end
        ST_SEL: begin
          if (pidx != LAST_CNT && !visit_mask[paddr]) begin
            pidx <= pidx + PCNT_W'(1);
          end
        end
        ST_WR_OWN: begin
          steady[paddr] <= !gave;
          pidx          <= pidx + PCNT_W'(1);
        end
        ST_STOP: begin
          stopped <= all_steady || (tick >= max_ticks);
        end
        ST_CHECK: begin
          pidx <= '0;
          if (!all_steady) begin
            done <= 1'b1;
          end
        end
        ST_SUM: begin
          pidx <= (pidx == LAST_CNT) ? '0 : pidx + PCNT_W'(1);
        end
        ST_DEV: begin
          if (pidx == LAST_CNT) begin
            pidx <= '0;
            done <= 1'b1;
          end else begin
            pidx <= pidx + PCNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers and result
  always_ff @(posedge clk) begin
    unique case (state)
      ST_RD_LF: own_ld <= mem_rdata;
      ST_RD_RT: lf_ld  <= mem_rdata;
      ST_SUM3: begin
        rt_ld <= mem_rdata;
        acc   <= alu_y;
      end
      ST_DIV3: avg <= alu_y[LOAD_W-1:0];
      ST_CHECK: begin
        acc <= '0;
        if (!all_steady) begin
          result.tick_count <= tick;
          result.all_steady <= 1'b0;
          result.balanced   <= 1'b0;
          result.timed_out  <= stopped;
          result.stopped    <= stopped;
        end
      end
      ST_SUM: begin
        if (pidx != '0) begin
          acc <= alu_y;
        end
      end
      ST_MEAN: begin
        mean <= alu_y[LOAD_W-1:0];
        bal  <= 1'b1;
      end
      ST_DEV: begin
        if (pidx != '0 && alu_y[0]) begin
          bal <= 1'b0;
        end
        if (pidx == LAST_CNT) begin
          result.tick_count <= tick;
          result.all_steady <= 1'b1;
          result.balanced   <= bal && !alu_y[0];
          result.timed_out  <= 1'b0;
          result.stopped    <= stopped;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

### design/rnlb_load_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module rnlb_load_mem import rnlb_pkg::*; #(
  parameter int NUM_PROCS = NUM_PROCS_DEF,
  localparam int IDX_W = $clog2(NUM_PROCS)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              we,
  input  logic [IDX_W-1:0]  waddr,
  input  logic [LOAD_W-1:0] wdata,
  input  logic [IDX_W-1:0]  raddr,
  output logic [LOAD_W-1:0] rdata
);

  logic [LOAD_W-1:0]    mem [NUM_PROCS];
  logic [NUM_PROCS-1:0] valid;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Mark written entries; unwritten entries read as zero load
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= 1'b1;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= valid[raddr] ? mem[raddr] : '0;
  end

endmodule

`default_nettype wire

### design/rnlb_phase.sv
`timescale 1ns / 1ps
`default_nettype none

module rnlb_phase import rnlb_pkg::*; #(
  parameter int NUM_PROCS = NUM_PROCS_DEF,
  localparam int IDX_W = $clog2(NUM_PROCS)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  phase_cmd_t           cmd,
  output logic [NUM_PROCS-1:0] visit_mask
);

  logic [IVL_W-1:0]     interval [NUM_PROCS];
  logic [IVL_W-1:0]     rem      [NUM_PROCS];
  logic [IVL_W-1:0]     rem_next [NUM_PROCS];
  logic [IVL_W:0]       rem_inc  [NUM_PROCS];
  logic [NUM_PROCS-1:0] hit;

  // Advance each remainder of the tick count modulo its interval
  for (genvar p = 0; p < NUM_PROCS; p++) begin : g_rem
    assign rem_inc[p]  = {1'b0, rem[p]} + (IVL_W + 1)'(1);
    assign rem_next[p] = (rem_inc[p] == {1'b0, interval[p]}) ? '0 : rem_inc[p][IVL_W-1:0];
    assign hit[p]      = (interval[p] != '0) && (rem_next[p] == '0);
  end

  // Interval store
  always_ff @(posedge clk) begin
    if (cmd.set_en) begin
      interval[cmd.proc_index[IDX_W-1:0]] <= cmd.interval;
    end
  end

  // Remainders restart with the tick count; capture who is due on a tick
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int p = 0; p < NUM_PROCS; p++) begin
        rem[p] <= '0;
      end
      visit_mask <= '0;
    end else if (cmd.set_en) begin
      for (int p = 0; p < NUM_PROCS; p++) begin
        rem[p] <= '0;
      end
    end else if (cmd.tick_en) begin
      for (int p = 0; p < NUM_PROCS; p++) begin
        rem[p] <= rem_next[p];
      end
      visit_mask <= hit;
    end
  end

endmodule

`default_nettype wire

### design/rnlb_alu.sv
`timescale 1ns / 1ps
`default_nettype none

module rnlb_alu import rnlb_pkg::*; #(
  parameter int NUM_PROCS = NUM_PROCS_DEF,
  localparam int ACC_W = LOAD_W + $clog2(NUM_PROCS)
) (
  input  alu_op_t          op,
  input  logic [ACC_W-1:0] a,
  input  logic [ACC_W-1:0] b,
  input  logic [ACC_W-1:0] c,
  output logic [ACC_W-1:0] y
);

  // Floor divide by the ring size: reciprocal multiply, exact below 2**ACC_W
  localparam int DN_S = ACC_W + $clog2(NUM_PROCS);
  localparam int DN_M = (2 ** DN_S + NUM_PROCS - 1) / NUM_PROCS;
  localparam int K_W  = (DN_S > DIV3_SHIFT) ? DN_S : DIV3_SHIFT;
  localparam int P_W  = ACC_W + K_W;

  logic [K_W-1:0]   k;
  logic [P_W-1:0]   prod;
  logic [ACC_W-1:0] diff;

  // One constant multiplier shared by both divides
  always_comb begin
    k    = (op == ALU_DIV3) ? K_W'(DIV3_MULT) : K_W'(DN_M);
    prod = P_W'(a) * P_W'(k);
    diff = (a > b) ? a - b : b - a;
  end

  always_comb begin
    unique case (op)
      ALU_ADD3: y = a + b + c;
      ALU_DIV3: y = prod[DIV3_SHIFT +: ACC_W];
      ALU_DIVN: y = prod[DN_S +: ACC_W];
      ALU_DEV:  y = ACC_W'(diff > ACC_W'(NUM_PROCS));
      default:  y = '0;
    endcase
  end

endmodule

`default_nettype wire

### design/rnlb_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rnlb_checker import rnlb_pkg::*; (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done,
  input wire rsp_t result
);

  // A result arrives only when the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted request always turns the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("request accepted without going busy");

  // Results never come in consecutive cycles
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  // Balanced needs steadiness
  a_bal_steady: assert property (@(posedge clk) disable iff (rst)
      (done && result.balanced) |-> result.all_steady)
    else $error("balanced reported without steadiness");

  // Timeout means stopped and not steady
  a_timeout: assert property (@(posedge clk) disable iff (rst)
      (done && result.timed_out) |-> (result.stopped && !result.all_steady))
    else $error("timeout flag inconsistent");

endmodule

bind ring_neighbor_load_balancer rnlb_checker u_rnlb_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .result (result)
);

`default_nettype wire

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import rnlb_pkg::*;

  localparam int NPROC = NUM_PROCS_DEF;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int DRAIN_CYCLES = 70;
  localparam int LIVE_TARGET = 1700;
  localparam rsp_t RSP_IDLE = '0;

  typedef struct {
    req_t req;
    bit   known;
    rsp_t want;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  req_t              request = '0;
  logic              busy;
  logic              done;
  rsp_t              result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [TICK_W-1:0] cfg_data = '0;

  // Mirror of the ring state and the timeout register
  logic [LOAD_W-1:0] ring_load [NPROC];
  logic [IVL_W-1:0]  ring_ivl [NPROC];
  bit                ring_steady [NPROC];
  logic [TICK_W-1:0] tick_now;
  bit                run_halted;
  logic [TICK_W-1:0] tick_limit;

  rsp_t      pending_status [$];
  stim_row_t plan [$];
  int        fail_count = 0;
  int        live_items = 0;
  int        cycle_count = 0;

  ring_neighbor_load_balancer u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Apply one request to the mirror and return the status it leaves behind
  function automatic rsp_t balance_step(input req_t r, output bit took_effect);
    int   j, lf, rt, own, avg, sum, mean, dev;
    bit   gave, steady_all, even;
    rsp_t s;
    took_effect = 1'b0;
    if (r.operation == OP_SET) begin
      if (r.proc_index < NPROC) begin
        ring_load[r.proc_index] = r.load_value;
        ring_ivl[r.proc_index] = r.interval_value;
        ring_steady[r.proc_index] = 1'b0;
        tick_now = '0;
        run_halted = 1'b0;
        took_effect = 1'b1;
      end
    end else if (!run_halted) begin
      took_effect = 1'b1;
      tick_now = tick_now + 1'b1;
      // Visit due processors in index order, updating loads in place
      for (j = 0; j < NPROC; j++) begin
        if (ring_ivl[j] != 0 && tick_now % ring_ivl[j] == 0) begin
          lf = (j + NPROC - 1) % NPROC;
          rt = (j + 1) % NPROC;
          own = int'(ring_load[j]);
          avg = (own + int'(ring_load[lf]) + int'(ring_load[rt])) / 3;
          gave = 1'b0;
          if (own > avg) begin
            if (int'(ring_load[lf]) < avg) begin
              own = own - (avg - int'(ring_load[lf]));
              ring_load[lf] = LOAD_W'(avg);
              gave = 1'b1;
            end
            if (int'(ring_load[rt]) < avg) begin
              own = own - (avg - int'(ring_load[rt]));
              ring_load[rt] = LOAD_W'(avg);
              gave = 1'b1;
            end
            ring_load[j] = LOAD_W'(own);
          end
          ring_steady[j] = !gave;
        end
      end
    end

    steady_all = 1'b1;
    sum = 0;
    for (j = 0; j < NPROC; j++) begin
      if (!ring_steady[j]) steady_all = 1'b0;
      sum += int'(ring_load[j]);
    end
    if (r.operation == OP_TICK && took_effect && (steady_all || tick_now >= tick_limit))
      run_halted = 1'b1;

    // Balanced when every load sits within NPROC of the floored mean
    mean = sum / NPROC;
    even = 1'b1;
    for (j = 0; j < NPROC; j++) begin
      dev = int'(ring_load[j]) - mean;
      if (dev < 0) dev = -dev;
      if (dev > NPROC) even = 1'b0;
    end

    s.tick_count = tick_now;
    s.all_steady = steady_all;
    s.balanced   = steady_all && even;
    s.timed_out  = run_halted && !steady_all;
    s.stopped    = run_halted;
    return s;
  endfunction

  function automatic req_t mk_set(input int idx, input int load, input int ivl);
    req_t r;
    r.operation      = OP_SET;
    r.proc_index     = IDX_FIELD_W'(idx);
    r.load_value     = LOAD_W'(load);
    r.interval_value = IVL_W'(ivl);
    return r;
  endfunction

  // Tick with random filler in the unused fields
  function automatic req_t mk_tick();
    req_t r;
    r.operation      = OP_TICK;
    r.proc_index     = IDX_FIELD_W'($urandom);
    r.load_value     = LOAD_W'($urandom);
    r.interval_value = IVL_W'($urandom);
    return r;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      fail_count++;
    end
  endfunction

  // Send one request after a gap; start stays high when the gap is zero
  task automatic issue(input req_t r, input int gap, input bit known, input rsp_t fixed);
    rsp_t want;
    bit   moved;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    want = balance_step(r, moved);
    if (moved) live_items++;
    pending_status.push_back(known ? fixed : want);
  endtask

  // Hold off until every outstanding request has reported
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_status.size() != 0);
  endtask

  task automatic write_limit(input int value);
    cfg_valid <= 1'b1;
    cfg_data <= TICK_W'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    tick_limit = TICK_W'(value);
  endtask

  // Check each status against the oldest prediction; watch the cycle budget
  always @(posedge clk) begin
    rsp_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t timeout", $time);
      $display("status: fail");
      $finish;
    end
    if (!rst && done) begin
      if (pending_status.size() == 0) begin
        $display("%0t unexpected status: expected none actual %p", $time, result);
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        check_field("tick_count", int'(want.tick_count), int'(result.tick_count));
        check_field("all_steady", int'(want.all_steady), int'(result.all_steady));
        check_field("balanced", int'(want.balanced), int'(result.balanced));
        check_field("timed_out", int'(want.timed_out), int'(result.timed_out));
        check_field("stopped", int'(want.stopped), int'(result.stopped));
      end
    end
  end

  initial begin
    int  phase, n_sets, n_ticks, mode, base, k, idx, load, ivl, lim;
    int  cfg_sweep [4] = '{1, 1048575, 0, 999999};

    for (k = 0; k < NPROC; k++) begin
      ring_load[k] = '0;
      ring_ivl[k] = '0;
      ring_steady[k] = 1'b0;
    end
    tick_now = '0;
    run_halted = 1'b0;
    tick_limit = MAX_TICKS_RST;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Short timeout so the zero-interval processor forces a timed-out stop
    write_limit(6);

    // Out-of-range sets, then every processor written before the first tick
    plan.push_back('{mk_set(15, 1023, 1023), 1'b1, RSP_IDLE});
    plan.push_back('{mk_set(5, 0, 0), 1'b1, RSP_IDLE});
    plan.push_back('{mk_set(0, 1023, 1), 1'b1, RSP_IDLE});
    plan.push_back('{mk_set(1, 0, 2), 1'b1, RSP_IDLE});
    plan.push_back('{mk_set(2, 0, 0), 1'b1, RSP_IDLE});
    plan.push_back('{mk_set(3, 1023, 1023), 1'b1, RSP_IDLE});
    plan.push_back('{mk_set(4, 0, 3), 1'b1, RSP_IDLE});
    // Run to timeout, then one tick while stopped
    for (k = 0; k < 7; k++) plan.push_back('{mk_tick(), 1'b0, RSP_IDLE});
    // Restart with every interval live and tick toward steadiness
    plan.push_back('{mk_set(2, 1, 1), 1'b1, RSP_IDLE});
    for (k = 0; k < 8; k++) plan.push_back('{mk_tick(), 1'b0, RSP_IDLE});
    plan.push_back('{mk_set(4, 700, 1), 1'b1, RSP_IDLE});
    plan.push_back('{mk_tick(), 1'b0, RSP_IDLE});

    foreach (plan[i])
      issue(plan[i].req, $urandom_range(0, 3), plan[i].known, plan[i].want);

    // Random runs: a few sets with random content, then a burst of ticks
    phase = 0;
    while (live_items < LIVE_TARGET) begin
      if (phase < 4 || $urandom_range(0, 3) == 0) begin
        drain();
        if (phase < 4) lim = cfg_sweep[phase];
        else if ($urandom_range(0, 1) == 0) lim = $urandom_range(2, 40);
        else lim = $urandom_range(0, 1048575);
        write_limit(lim);
      end
      mode = $urandom_range(0, 3);
      n_sets = $urandom_range(1, 6);
      base = $urandom_range(0, 1000);
      for (k = 0; k < n_sets; k++) begin
        idx = ($urandom_range(0, 9) == 0) ? $urandom_range(NPROC, 15) : $urandom_range(0, NPROC - 1);
        case ($urandom_range(0, 9))
          0, 1: load = $urandom_range(0, 1) ? 1023 : 0;
          2, 3, 4: begin
            load = base + $urandom_range(0, 20);
            if (load > 1023) load = 1023;
          end
          default: load = $urandom_range(0, 1023);
        endcase
        case ($urandom_range(0, 9))
          0: ivl = 0;
          1, 2: ivl = $urandom_range(1, 1023);
          default: ivl = $urandom_range(1, 4);
        endcase
        issue(mk_set(idx, load, ivl), (mode == 0) ? 0 : $urandom_range(0, 12), 1'b0, RSP_IDLE);
      end
      n_ticks = $urandom_range(4, 40);
      for (k = 0; k < n_ticks; k++) begin
        issue(mk_tick(), (mode == 0) ? 0 : $urandom_range(0, 12), 1'b0, RSP_IDLE);
        if (run_halted && $urandom_range(0, 3) != 0) break;
      end
      phase++;
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

### filelist.f
design/rnlb_pkg.sv
design/rnlb_load_mem.sv
design/rnlb_phase.sv
design/rnlb_alu.sv
design/ring_neighbor_load_balancer.sv
design/rnlb_checker.sv
sim/tb_top.sv
